[sv/chs_pkg.sv]
// Shared types and constants for the convex hull stack scan core.
package chs_pkg;

    localparam int XW = 29;
    localparam int YW = 28;
    localparam int PW = XW + YW + 2;

    typedef logic signed [XW-1:0] coord_x_t;
    typedef logic signed [YW-1:0] coord_y_t;

    typedef struct packed {
        coord_x_t x;
        coord_y_t y;
    } point_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_PUSH,
        ST_DRAIN
    } state_t;

endpackage

[sv/chs_cell.sv]
// One stack cell: holds a point and shifts with its neighbours on push and pop.
module chs_cell (
    input  logic              clk,
    input  chs_pkg::cell_op_t op,
    input  chs_pkg::point_t   from_above,
    input  chs_pkg::point_t   from_below,
    output chs_pkg::point_t   q
);
    import chs_pkg::*;

    point_t pt_reg;
    point_t pt_next;

    always_comb
    begin
        unique case (op)
            CELL_PUSH: pt_next = from_above;
            CELL_POP:  pt_next = from_below;
            default:   pt_next = pt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    assign q = pt_reg;

endmodule

[sv/chs_orient.sv]
// Orientation test: registered cross products of the top two entries and the new point.
module chs_orient (
    input  logic            clk,
    input  logic            load,
    input  chs_pkg::point_t a,
    input  chs_pkg::point_t b,
    input  chs_pkg::point_t c,
    output logic            pop_hit
);
    import chs_pkg::*;

    logic signed [XW:0]   dxb;
    logic signed [XW:0]   dxc;
    logic signed [YW:0]   dyb;
    logic signed [YW:0]   dyc;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;

    assign dxb = $signed({b.x[XW-1], b.x}) - $signed({a.x[XW-1], a.x});
    assign dxc = $signed({c.x[XW-1], c.x}) - $signed({a.x[XW-1], a.x});
    assign dyb = $signed({b.y[YW-1], b.y}) - $signed({a.y[YW-1], a.y});
    assign dyc = $signed({c.y[YW-1], c.y}) - $signed({a.y[YW-1], a.y});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p1_reg <= dxb * dyc;
            p2_reg <= dyb * dxc;
        end
    end

    // cross >= 0 means the top entry is not a strict left turn: pop it
    assign pop_hit = (p1_reg >= p2_reg);

endmodule

[sv/convex_hull_stack_scan_core.sv]
// Convex hull over pre-sorted points: a shifting stack of cells, an orientation
// unit and a readout stage. A point is taken in ST_IDLE; each orientation test
// then passes through ST_MUL, which registers the two products, and ST_CMP, which
// pops or pushes, with ST_PUSH doing the push when the stack holds fewer than two
// entries on arrival or after popping. A final point then reads the stack out
// top-first, one vertex per cycle while the output is taken, the last marked by
// end_of_hull. A push onto a full stack is dropped and sets overflowed, which
// stays set until reset. The output register lets the next point be taken while
// the last vertex still waits for transfer.
module convex_hull_stack_scan_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_ready,
    input  chs_pkg::coord_x_t point_x,
    input  chs_pkg::coord_y_t point_y,
    input  logic              final_point,
    output logic              hull_valid,
    input  logic              hull_ready,
    output chs_pkg::coord_x_t hull_x,
    output chs_pkg::coord_y_t hull_y,
    output logic              end_of_hull,
    output logic              overflowed
);
    import chs_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);
    localparam logic [CW-1:0] CNT_TWO   = CW'(2);
    localparam logic [CW-1:0] CNT_THREE = CW'(3);
    localparam logic [CW-1:0] CNT_FULL  = CW'(STACK_DEPTH);

    state_t        state_reg, state_next;
    point_t        pt_reg, pt_next;
    logic          last_reg, last_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;
    point_t        out_pt_reg, out_pt_next;
    logic          out_end_reg, out_end_next;
    logic          out_ovf_reg, out_ovf_next;

    cell_op_t      stack_op;
    logic          orient_load;
    logic          pop_hit;

    point_t        above [STACK_DEPTH];
    point_t        below [STACK_DEPTH];
    point_t        q     [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_top
            assign above[i] = pt_reg;
        end
        else
        begin : g_inner
            assign above[i] = q[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign below[i] = q[i];
        end
        else
        begin : g_upper
            assign below[i] = q[i+1];
        end

        chs_cell u_cell (
            .clk        (clk),
            .op         (stack_op),
            .from_above (above[i]),
            .from_below (below[i]),
            .q          (q[i])
        );
    end

    chs_orient u_orient (
        .clk     (clk),
        .load    (orient_load),
        .a       (q[0]),
        .b       (q[1]),
        .c       (pt_reg),
        .pop_hit (pop_hit)
    );

    assign point_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pt_next        = pt_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_pt_next    = out_pt_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;
        stack_op       = CELL_HOLD;
        orient_load    = 1'b0;

        if (out_valid_reg && hull_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (point_valid)
                begin
                    pt_next.x  = point_x;
                    pt_next.y  = point_y;
                    last_next  = final_point;
                    state_next = (count_reg >= CNT_TWO) ? ST_MUL : ST_PUSH;
                end
            end
            ST_MUL:
            begin
                orient_load = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP, ST_PUSH:
            begin
                if (state_reg == ST_CMP && pop_hit)
                begin
                    stack_op   = CELL_POP;
                    count_next = count_reg - CNT_ONE;
                    state_next = (count_reg >= CNT_THREE) ? ST_MUL : ST_PUSH;
                end
                else
                begin
                    if (count_reg < CNT_FULL)
                    begin
                        stack_op   = CELL_PUSH;
                        count_next = count_reg + CNT_ONE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = last_reg ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (!out_valid_reg || hull_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pt_next    = q[0];
                    out_end_next   = (count_reg == CNT_ONE);
                    out_ovf_next   = ovf_reg;
                    stack_op       = CELL_POP;
                    count_next     = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg      <= pt_next;
        last_reg    <= last_next;
        out_pt_reg  <= out_pt_next;
        out_end_reg <= out_end_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign hull_valid  = out_valid_reg;
    assign hull_x      = out_pt_reg.x;
    assign hull_y      = out_pt_reg.y;
    assign end_of_hull = out_end_reg;
    assign overflowed  = out_ovf_reg;

endmodule

[sv/chs_checker.sv]
// Port-level checks for the convex hull stack scan core, with its bind.
module chs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              point_valid,
    input logic              point_ready,
    input chs_pkg::coord_x_t point_x,
    input chs_pkg::coord_y_t point_y,
    input logic              final_point,
    input logic              hull_valid,
    input logic              hull_ready,
    input chs_pkg::coord_x_t hull_x,
    input chs_pkg::coord_y_t hull_y,
    input logic              end_of_hull,
    input logic              overflowed
);
    import chs_pkg::*;

    // stalled result holds
    a_hull_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid && !hull_ready |=> hull_valid && $stable(hull_x) && $stable(hull_y)
            && $stable(end_of_hull) && $stable(overflowed))
        else $error("hull output changed while stalled");

    // a readout is one burst: no new point until its last vertex is loaded
    a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid && !end_of_hull |-> !point_ready)
        else $error("point accepted during hull readout");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid |-> !$isunknown({hull_x, hull_y, end_of_hull, overflowed}))
        else $error("unknown value on presented vertex");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid && overflowed |=> !hull_valid || overflowed)
        else $error("overflow flag cleared");

    a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready |=> !point_ready)
        else $error("second point accepted while first still in work");

endmodule

bind convex_hull_stack_scan_core chs_checker u_chs_checker (.*);
